@@ rtl/bntg_pkg.sv @@
package bntg_pkg;

  localparam int unsigned TickW   = 20;
  localparam int unsigned ToneW   = 16;
  localparam int unsigned CodeW   = 11;
  localparam int unsigned BeatW   = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] TicksPerBeatRst = TickW'(125000);
  localparam logic [TickW-1:0] GapTicksRst     = TickW'(30000);
  localparam logic [ToneW-1:0] ToneTop         = '1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_BEAT = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_GAP_TICKS      = CfgIdxW'(1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SOUND = 2'd1,
    PH_GAP   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [BeatW-1:0]  beats;
    logic [DigitW-1:0] octave;
    logic [DigitW-1:0] degree;
  } note_dec_t;

  // Splits the decimal note word into its digits. Division by 100 is a multiply by
  // 5243 / 2^19, exact for every 11-bit word; division by 10 of the remainder is a
  // multiply by 205 / 2^11, exact below 1029.
  function automatic note_dec_t decode_note(input logic [CodeW-1:0] code);
    logic [23:0]       q_prod;
    logic [BeatW-1:0]  beats;
    logic [CodeW-1:0]  rem_w;
    logic [6:0]        rem;
    logic [14:0]       t_prod;
    logic [DigitW-1:0] tens;
    logic [6:0]        units_w;
    note_dec_t         d;
    q_prod  = 24'(code) * 24'd5243;
    beats   = q_prod[23:19];
    rem_w   = code - CodeW'(beats) * CodeW'(100);
    rem     = rem_w[6:0];
    t_prod  = 15'(rem) * 15'd205;
    tens    = t_prod[14:11];
    units_w = rem - 7'(tens) * 7'd10;
    d.beats  = beats;
    d.octave = tens;
    d.degree = units_w[DigitW-1:0];
    return d;
  endfunction

  function automatic logic [ToneW-1:0] tone_lookup(input logic [1:0] octave,
                                                   input logic [2:0] degree);
    logic [ToneW-1:0] r;
    case ({octave, degree})
      5'b00_001: r = 16'hF88C;
      5'b00_010: r = 16'hF95B;
      5'b00_011: r = 16'hFA15;
      5'b00_100: r = 16'hFA67;
      5'b00_101: r = 16'hFB04;
      5'b00_110: r = 16'hFB90;
      5'b00_111: r = 16'hFC0C;
      5'b01_001: r = 16'hFC44;
      5'b01_010: r = 16'hFCAC;
      5'b01_011: r = 16'hFD09;
      5'b01_100: r = 16'hFD34;
      5'b01_101: r = 16'hFD82;
      5'b01_110: r = 16'hFDC8;
      5'b01_111: r = 16'hFE06;
      5'b10_001: r = 16'hFE22;
      5'b10_010: r = 16'hFE56;
      5'b10_011: r = 16'hFE85;
      5'b10_100: r = 16'hFE9A;
      5'b10_101: r = 16'hFEC1;
      5'b10_110: r = 16'hFEE4;
      5'b10_111: r = 16'hFF03;
      default:   r = ToneTop;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bntg_if.sv @@
interface bntg_in_if import bntg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CodeW-1:0] note_code;

  modport source (output valid, output kind, output note_code, input ready);
  modport sink   (input valid, input kind, input note_code, output ready);
endinterface

interface bntg_out_if;
  logic valid;
  logic ready;
  logic speaker;
  logic note_done;

  modport source (output valid, output speaker, output note_done, input ready);
  modport sink   (input valid, input speaker, input note_done, output ready);
endinterface

interface bntg_cfg_if import bntg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TickW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/buzzer_note_tone_generator.sv @@
// The result of an item is in the output register in the cycle after its transaction.
// Throughput: one item per cycle; the tone and phase state is updated by a single
// combinational pass at each accepted transaction and read back by the next one.
// The input is held off only while a result waits in the output register and is not taken.
// Reset (rst_ni low, asynchronous): idle, speaker low, tone counter and reload all ones,
// 125000 ticks per beat, 30000 gap ticks, output register empty.
module buzzer_note_tone_generator import bntg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bntg_in_if.sink           in_i,
  bntg_out_if.source        out_o,
  bntg_cfg_if.sink          cfg_i
);

  logic [TickW-1:0] tpb_q, gap_q;
  logic             speaker_q, speaker_d;
  logic [ToneW-1:0] tone_cnt_q, tone_cnt_d;
  logic [ToneW-1:0] tone_reload_q, tone_reload_d;
  phase_e           phase_q, phase_d;
  logic             tone_run_q, tone_run_d;
  logic [BeatW-1:0] beats_left_q, beats_left_d;
  logic [TickW-1:0] phase_ticks_q, phase_ticks_d;
  logic             done_d;

  logic             out_valid_q, out_valid_d;
  logic             out_speaker_q;
  logic             out_done_q;

  logic             in_fire, out_fire;
  note_dec_t        dec;
  logic             is_tone;
  logic [TickW:0]   next_ticks;
  logic [BeatW-1:0] beats_dec;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_valid_q && out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid     = out_valid_q;
  assign out_o.speaker   = out_speaker_q;
  assign out_o.note_done = out_done_q;

  assign dec     = decode_note(in_i.note_code);
  assign is_tone = (dec.degree != '0) && (dec.degree <= DigitW'(7)) &&
                   (dec.octave <= DigitW'(2));
  assign next_ticks = {1'b0, phase_ticks_q} + (TickW+1)'(1);

  always_comb begin
    speaker_d     = speaker_q;
    tone_cnt_d    = tone_cnt_q;
    tone_reload_d = tone_reload_q;
    phase_d       = phase_q;
    tone_run_d    = tone_run_q;
    beats_left_d  = beats_left_q;
    phase_ticks_d = phase_ticks_q;
    done_d        = 1'b0;
    beats_dec     = beats_left_q;
    if (in_i.kind) begin
      // A new note restarts playback; the speaker keeps its level.
      if (is_tone) begin
        tone_reload_d = tone_lookup(dec.octave[1:0], dec.degree[2:0]);
        tone_cnt_d    = tone_reload_d;
        tone_run_d    = 1'b1;
      end else begin
        tone_run_d = 1'b0;
      end
      phase_ticks_d = '0;
      beats_left_d  = dec.beats;
      if (dec.beats == '0) begin
        tone_run_d = 1'b0;
        phase_d    = PH_GAP;
      end else begin
        phase_d = PH_SOUND;
      end
    end else begin
      if (tone_run_q) begin
        if (tone_cnt_q == ToneTop) begin
          tone_cnt_d = tone_reload_q;
          speaker_d  = !speaker_q;
        end else begin
          tone_cnt_d = tone_cnt_q + ToneW'(1);
        end
      end
      case (phase_q)
        PH_SOUND: begin
          if (next_ticks >= {1'b0, tpb_q}) begin
            phase_ticks_d = '0;
            if (beats_left_q != '0) begin
              beats_dec = beats_left_q - BeatW'(1);
            end
            beats_left_d = beats_dec;
            if (beats_dec == '0) begin
              tone_run_d = 1'b0;
              phase_d    = PH_GAP;
            end
          end else begin
            phase_ticks_d = next_ticks[TickW-1:0];
          end
        end
        PH_GAP: begin
          // A gap of zero still takes one tick.
          if (next_ticks >= {1'b0, gap_q}) begin
            phase_ticks_d = '0;
            phase_d       = PH_IDLE;
            done_d        = 1'b1;
          end else begin
            phase_ticks_d = next_ticks[TickW-1:0];
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q         <= TicksPerBeatRst;
      gap_q         <= GapTicksRst;
      speaker_q     <= 1'b0;
      tone_cnt_q    <= ToneTop;
      tone_reload_q <= ToneTop;
      phase_q       <= PH_IDLE;
      tone_run_q    <= 1'b0;
      beats_left_q  <= '0;
      phase_ticks_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_TICKS_PER_BEAT) begin
          tpb_q <= cfg_i.data;
        end else if (cfg_i.index == CFG_GAP_TICKS) begin
          gap_q <= cfg_i.data;
        end
      end
      if (in_fire) begin
        speaker_q     <= speaker_d;
        tone_cnt_q    <= tone_cnt_d;
        tone_reload_q <= tone_reload_d;
        phase_q       <= phase_d;
        tone_run_q    <= tone_run_d;
        beats_left_q  <= beats_left_d;
        phase_ticks_q <= phase_ticks_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_speaker_q <= speaker_d;
      out_done_q    <= done_d;
    end
  end

  // The tone only runs while a note is sounding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_run_q |-> (phase_q == PH_SOUND))
    else $error("tone running outside the sounding phase");

  // A sounding note always has at least one beat left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SOUND) |-> (beats_left_q != '0))
    else $error("sounding phase with no beats left");

  // The end of a gap leaves the player idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && done_d) |=> (phase_q == PH_IDLE))
    else $error("note finished but player not idle");

  // A note word never reports a finished note.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.kind) |=> (out_o.valid && !out_o.note_done))
    else $error("note word produced a done pulse");

endmodule
